>>> rtl/semaphore_bank_with_wait_queues_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the semaphore bank
// Shared property wrappers; every use samples on clk_i and is disabled
// while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SEMAPHORE_BANK_WITH_WAIT_QUEUES_MACROS_SVH
`define SEMAPHORE_BANK_WITH_WAIT_QUEUES_MACROS_SVH

// A property that must hold at every clock edge.
`define SBWQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define SBWQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SBWQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/sbwq_pkg.sv
// ----------------------------------------------------------------------------
// sbwq_pkg
// Sizes, command and status codes and the shared unit's operand types for
// the semaphore bank with wait queues.
// ----------------------------------------------------------------------------
`default_nettype none

package sbwq_pkg;

  localparam int unsigned NUM_SEMS    = 5;
  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned PID_BITS    = 8;

  // Port field widths.
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned SID_W    = 3;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned PID_IN_W = 8;
  localparam int unsigned STATUS_W = 3;

  // Derived sizes.
  localparam int unsigned SEM_W     = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
  localparam int unsigned SEMC_W    = $clog2(NUM_SEMS + 1);
  localparam int unsigned PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned LEN_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned RAM_DEPTH = NUM_SEMS * QUEUE_DEPTH;
  localparam int unsigned ADDR_W    = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_CREATE = 2'd0,
    CMD_WAIT   = 2'd1,
    CMD_SIGNAL = 2'd2,
    CMD_REMOVE = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_ID    = 3'd1,
    ST_UNINIT    = 3'd2,
    ST_CREATED   = 3'd3,
    ST_AT_MAX    = 3'd4,
    ST_FULL      = 3'd5,
    ST_NOT_FOUND = 3'd6
  } status_e;

  // Operands of the shared add and compare unit.
  typedef struct packed {
    logic [VAL_W-1:0] a;
    logic [VAL_W-1:0] b;
    logic [VAL_W-1:0] c;
  } unit_req_t;

  typedef struct packed {
    logic [VAL_W:0] sum;
    logic           eq;
  } unit_rsp_t;

endpackage

`default_nettype wire

>>> rtl/semaphore_bank_with_wait_queues.sv
// ----------------------------------------------------------------------------
// semaphore_bank_with_wait_queues
// Bank of counting semaphores with FIFO wait queues held as circular
// buffers in one RAM, run by a sequencer around a shared add/compare unit.
// ----------------------------------------------------------------------------
//  Channel  Valid        Stall        Payload
//  in       in_valid_i   in_stall_o   cmd_i, sem_id_i, init_value_i, proc_id_i
//  out      out_valid_o  out_stall_i  status_o, blocked_o, woke_valid_o,
//                                     woke_pid_o, woke_is_init_o
//
//  Create, wait and signal pass S_EXEC and S_DONE; a signal that wakes a
//  waiter also passes S_POP (one RAM read). Remove waiter walks the queues
//  over the single RAM read port: S_SRCH_CHK, S_SRCH_CMP per entry compared,
//  S_SRCH_CHK per semaphore passed, S_SHIFT_CHK, S_SHIFT_WR per entry shifted.
//  One command is in flight at a time; the next is taken while the result
//  register still waits on out_stall_i.
//  Reset clears all semaphores at once; the queue RAM needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

`include "semaphore_bank_with_wait_queues_macros.svh"

module semaphore_bank_with_wait_queues import sbwq_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [CMD_W-1:0]    cmd_i,
  input  wire logic [SID_W-1:0]    sem_id_i,
  input  wire logic [VAL_W-1:0]    init_value_i,
  input  wire logic [PID_IN_W-1:0] proc_id_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [STATUS_W-1:0]      status_o,
  output logic                     blocked_o,
  output logic                     woke_valid_o,
  output logic [PID_IN_W-1:0]      woke_pid_o,
  output logic                     woke_is_init_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POP,
    S_SRCH_CHK,
    S_SRCH_CMP,
    S_SHIFT_CHK,
    S_SHIFT_WR,
    S_DONE
  } state_e;

  localparam logic [SID_W:0]   NUM_SEMS_C = (SID_W + 1)'(NUM_SEMS);
  localparam logic [SEMC_W-1:0] SEM_END   = SEMC_W'(NUM_SEMS);
  localparam logic [LEN_W-1:0] QD_LEN     = LEN_W'(QUEUE_DEPTH);
  localparam logic [LEN_W:0]   QD_WIDE    = (LEN_W + 1)'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST   = PTR_W'(QUEUE_DEPTH - 1);

  state_e               state_q, state_d;
  cmd_e                 cmd_q, cmd_d;
  logic [SID_W-1:0]     sid_q, sid_d;
  logic [VAL_W-1:0]     init_q, init_d;
  logic [PID_BITS-1:0]  pid_q, pid_d;
  logic [SEMC_W-1:0]    s_q, s_d;
  logic [LEN_W-1:0]     j_q, j_d;

  status_e              res_status_q, res_status_d;
  logic                 res_blocked_q, res_blocked_d;
  logic                 res_wv_q, res_wv_d;
  logic [PID_BITS-1:0]  res_wp_q, res_wp_d;
  logic                 res_wi_q, res_wi_d;

  logic                 created_q [NUM_SEMS];
  logic                 created_d [NUM_SEMS];
  logic [VAL_W-1:0]     count_q   [NUM_SEMS];
  logic [VAL_W-1:0]     count_d   [NUM_SEMS];
  logic [LEN_W-1:0]     len_q     [NUM_SEMS];
  logic [LEN_W-1:0]     len_d     [NUM_SEMS];
  logic [PTR_W-1:0]     head_q    [NUM_SEMS];
  logic [PTR_W-1:0]     head_d    [NUM_SEMS];

  logic                 out_valid_q, out_valid_d;
  status_e              status_q, status_d;
  logic                 blocked_q, blocked_d;
  logic                 woke_valid_q, woke_valid_d;
  logic [PID_IN_W-1:0]  woke_pid_q, woke_pid_d;
  logic                 woke_is_init_q, woke_is_init_d;

  logic                 sid_ok;
  logic [SEM_W-1:0]     sidx;
  logic                 s_in;
  logic [SEM_W-1:0]     ssel;
  logic [LEN_W-1:0]     j_inc;
  logic [SEM_W-1:0]     sem_a;
  logic [LEN_W-1:0]     off_a;
  logic [LEN_W:0]       pos_sum;
  logic [LEN_W:0]       pos_w;
  logic [ADDR_W-1:0]    addr;
  logic                 ram_we;
  logic [PID_BITS-1:0]  ram_wdata;
  logic [PID_BITS-1:0]  ram_rdata;
  unit_req_t            unit_req;
  unit_rsp_t            unit_rsp;

  // Index guards keep array reads in range when the id is invalid.
  assign sid_ok = ({1'b0, sid_q} < NUM_SEMS_C);
  assign sidx   = sid_ok ? sid_q[SEM_W-1:0] : '0;
  assign s_in   = (s_q < SEM_END);
  assign ssel   = s_in ? s_q[SEM_W-1:0] : '0;
  assign j_inc  = j_q + LEN_W'(1);

  // Queue slot address: semaphore base plus (head + offset) wrapped.
  always_comb begin
    case (state_q)
      S_EXEC: begin
        sem_a = sidx;
        off_a = (cmd_q == CMD_WAIT) ? len_q[sidx] : '0;
      end
      S_SRCH_CHK, S_SHIFT_WR: begin
        sem_a = ssel;
        off_a = j_q;
      end
      S_SHIFT_CHK: begin
        sem_a = ssel;
        off_a = j_inc;
      end
      default: begin
        sem_a = sidx;
        off_a = '0;
      end
    endcase
  end

  assign pos_sum = (LEN_W + 1)'(head_q[sem_a]) + (LEN_W + 1)'(off_a);
  assign pos_w   = (pos_sum >= QD_WIDE) ? (pos_sum - QD_WIDE) : pos_sum;
  assign addr    = ADDR_W'(sem_a) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(pos_w[PTR_W-1:0]);

  // Shared unit operands: count arithmetic, or the id match while searching.
  always_comb begin
    unit_req.a = count_q[sidx];
    unit_req.b = (cmd_q == CMD_WAIT) ? '1 : VAL_W'(1);
    unit_req.c = '0;
    if (state_q == S_SRCH_CMP) begin
      unit_req.a = VAL_W'(ram_rdata);
      unit_req.b = '0;
      unit_req.c = VAL_W'(pid_q);
    end
  end

  sbwq_unit u_unit (
    .req_i (unit_req),
    .rsp_o (unit_rsp)
  );

  sbwq_ram #(
    .DEPTH (RAM_DEPTH),
    .WIDTH (PID_BITS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr),
    .wdata_i (ram_wdata),
    .raddr_i (addr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d        = state_q;
    cmd_d          = cmd_q;
    sid_d          = sid_q;
    init_d         = init_q;
    pid_d          = pid_q;
    s_d            = s_q;
    j_d            = j_q;
    res_status_d   = res_status_q;
    res_blocked_d  = res_blocked_q;
    res_wv_d       = res_wv_q;
    res_wp_d       = res_wp_q;
    res_wi_d       = res_wi_q;
    created_d      = created_q;
    count_d        = count_q;
    len_d          = len_q;
    head_d         = head_q;
    ram_we         = 1'b0;
    ram_wdata      = pid_q;
    // The result register empties on its transfer.
    out_valid_d    = out_valid_q && out_stall_i;
    status_d       = status_q;
    blocked_d      = blocked_q;
    woke_valid_d   = woke_valid_q;
    woke_pid_d     = woke_pid_q;
    woke_is_init_d = woke_is_init_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d         = cmd_e'(cmd_i);
          sid_d         = sem_id_i;
          init_d        = init_value_i;
          pid_d         = PID_BITS'(proc_id_i);
          res_status_d  = ST_OK;
          res_blocked_d = 1'b0;
          res_wv_d      = 1'b0;
          res_wp_d      = '0;
          res_wi_d      = 1'b0;
          state_d       = S_EXEC;
        end
      end

      S_EXEC: begin
        state_d = S_DONE;
        if (cmd_q == CMD_REMOVE) begin
          s_d     = '0;
          j_d     = '0;
          state_d = S_SRCH_CHK;
        end else if (!sid_ok) begin
          res_status_d = ST_BAD_ID;
        end else begin
          case (cmd_q)
            CMD_CREATE: begin
              if (created_q[sidx]) begin
                res_status_d = ST_CREATED;
              end else begin
                created_d[sidx] = 1'b1;
                count_d[sidx]   = init_q;
                len_d[sidx]     = '0;
                head_d[sidx]    = '0;
              end
            end
            CMD_WAIT: begin
              if (!created_q[sidx]) begin
                res_status_d = ST_UNINIT;
              end else if (!unit_rsp.eq) begin
                count_d[sidx] = unit_rsp.sum[VAL_W-1:0];
              end else if (len_q[sidx] >= QD_LEN) begin
                res_status_d = ST_FULL;
              end else begin
                ram_we        = 1'b1;
                len_d[sidx]   = len_q[sidx] + LEN_W'(1);
                res_blocked_d = 1'b1;
              end
            end
            CMD_SIGNAL: begin
              if (!created_q[sidx]) begin
                res_status_d = ST_UNINIT;
              end else if (unit_rsp.eq && (len_q[sidx] != '0)) begin
                // The head slot is read this cycle; its id lands in S_POP.
                head_d[sidx] = (head_q[sidx] == PTR_LAST) ? '0
                                                          : head_q[sidx] + PTR_W'(1);
                len_d[sidx]  = len_q[sidx] - LEN_W'(1);
                state_d      = S_POP;
              end else if (unit_rsp.sum[VAL_W]) begin
                res_status_d = ST_AT_MAX;
              end else begin
                count_d[sidx] = unit_rsp.sum[VAL_W-1:0];
              end
            end
            default: begin
              res_status_d = ST_OK;
            end
          endcase
        end
      end

      S_POP: begin
        res_wv_d = 1'b1;
        res_wp_d = ram_rdata;
        res_wi_d = (ram_rdata == '0);
        state_d  = S_DONE;
      end

      S_SRCH_CHK: begin
        if (!s_in) begin
          res_status_d = ST_NOT_FOUND;
          state_d      = S_DONE;
        end else if (!created_q[ssel] || (j_q >= len_q[ssel])) begin
          s_d = s_q + SEMC_W'(1);
          j_d = '0;
        end else begin
          state_d = S_SRCH_CMP;
        end
      end

      S_SRCH_CMP: begin
        if (unit_rsp.eq) begin
          state_d = S_SHIFT_CHK;
        end else begin
          j_d     = j_inc;
          state_d = S_SRCH_CHK;
        end
      end

      S_SHIFT_CHK: begin
        // Later entries move up one slot until the tail is reached.
        if (j_inc >= len_q[ssel]) begin
          len_d[ssel] = len_q[ssel] - LEN_W'(1);
          state_d     = S_DONE;
        end else begin
          state_d = S_SHIFT_WR;
        end
      end

      S_SHIFT_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        j_d       = j_inc;
        state_d   = S_SHIFT_CHK;
      end

      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d    = 1'b1;
          status_d       = res_status_q;
          blocked_d      = res_blocked_q;
          woke_valid_d   = res_wv_q;
          woke_pid_d     = PID_IN_W'(res_wp_q);
          woke_is_init_d = res_wi_q;
          state_d        = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      cmd_q          <= CMD_CREATE;
      sid_q          <= '0;
      init_q         <= '0;
      pid_q          <= '0;
      s_q            <= '0;
      j_q            <= '0;
      res_status_q   <= ST_OK;
      res_blocked_q  <= 1'b0;
      res_wv_q       <= 1'b0;
      res_wp_q       <= '0;
      res_wi_q       <= 1'b0;
      created_q      <= '{default: 1'b0};
      count_q        <= '{default: '0};
      len_q          <= '{default: '0};
      head_q         <= '{default: '0};
      out_valid_q    <= 1'b0;
      status_q       <= ST_OK;
      blocked_q      <= 1'b0;
      woke_valid_q   <= 1'b0;
      woke_pid_q     <= '0;
      woke_is_init_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      cmd_q          <= cmd_d;
      sid_q          <= sid_d;
      init_q         <= init_d;
      pid_q          <= pid_d;
      s_q            <= s_d;
      j_q            <= j_d;
      res_status_q   <= res_status_d;
      res_blocked_q  <= res_blocked_d;
      res_wv_q       <= res_wv_d;
      res_wp_q       <= res_wp_d;
      res_wi_q       <= res_wi_d;
      created_q      <= created_d;
      count_q        <= count_d;
      len_q          <= len_d;
      head_q         <= head_d;
      out_valid_q    <= out_valid_d;
      status_q       <= status_d;
      blocked_q      <= blocked_d;
      woke_valid_q   <= woke_valid_d;
      woke_pid_q     <= woke_pid_d;
      woke_is_init_q <= woke_is_init_d;
    end
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign blocked_o      = blocked_q;
  assign woke_valid_o   = woke_valid_q;
  assign woke_pid_o     = woke_pid_q;
  assign woke_is_init_o = woke_is_init_q;

  // Queue bookkeeping per semaphore.
  for (genvar g = 0; g < NUM_SEMS; g++) begin : g_sem_chk
    `SBWQ_ASSERT(a_len_bound, len_q[g] <= QD_LEN, "wait queue length beyond depth")
    `SBWQ_ASSERT_IMPL(a_uncreated_empty, !created_q[g], len_q[g] == '0, "uncreated with waiters")
  end

  `SBWQ_ASSERT_IMPL(a_woke_ok, woke_valid_q, status_q == ST_OK && !blocked_q, "bad wake")
  `SBWQ_ASSERT_NEXT(a_accept_busy, in_valid_i && !in_stall_o, in_stall_o, "busy after transfer")

endmodule

`default_nettype wire

>>> rtl/sbwq_ram.sv
// ----------------------------------------------------------------------------
// sbwq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module sbwq_ram #(
  parameter  int unsigned DEPTH = 2,
  parameter  int unsigned WIDTH = 8,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/sbwq_unit.sv
// ----------------------------------------------------------------------------
// sbwq_unit
// Shared arithmetic unit: one 33-bit add and one 32-bit equality compare.
// Serves count increment and decrement, the maximum and zero checks and
// the process id match during the queue search.
// ----------------------------------------------------------------------------
`default_nettype none

module sbwq_unit import sbwq_pkg::*; (
  input  wire unit_req_t req_i,
  output unit_rsp_t      rsp_o
);

  assign rsp_o.sum = {1'b0, req_i.a} + {1'b0, req_i.b};
  assign rsp_o.eq  = (req_i.a == req_i.c);

endmodule

`default_nettype wire
